### hdl/hbf_pkg.sv
package hbf_pkg;

  localparam int MAX_HARMONICS_DEF   = 8;
  localparam int MAX_SLICES_DEF      = 1024;
  localparam int SINE_TABLE_BITS_DEF = 10;

  // sine polynomial coefficients, Q16
  localparam longint POLY_A = 102944;
  localparam longint POLY_B = 42048;
  localparam longint POLY_C = 4640;

  localparam int SINE_W  = 15;  // magnitude of a Q1.15 sample
  localparam int ACC_W   = 48;
  localparam int WT_W    = 32;
  localparam int FIELD_W = 32;
  localparam int CMP_W   = 6;   // holds any harmonic count up to 63
  localparam int DIV_W   = 64;
  localparam int DCNT_W  = 6;

  localparam logic [3:0]         HC_RESET    = 4'd1;
  localparam logic [FIELD_W-1:0] SCALE_RESET = 32'hFFFF_0000;

  typedef enum logic [0:0] {
    CFG_HARMONIC_COUNT = 1'b0,
    CFG_FIELD_SCALE    = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_LOAD1,
    ST_DIV1,
    ST_CLAMP,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_LOAD2,
    ST_DIV2,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage

### hdl/harmonic_bunching_field_unit.sv
// Channel    | Ports                                         | Handshake
// -----------+-----------------------------------------------+-------------------------------
// particle   | phase, weight, slice_end                      | start high, busy low
// result     | slice_index, harmonic, field_real, field_imag,| result_strobe, one cycle each,
//            | empty_slice, last_of_run                      | no back-pressure
// config     | cfg_we, cfg_index, cfg_data                   | write at edge with cfg_we high
//
// Flow: a particle holds busy while its harmonics pass one per cycle through the sine ROM,
// multipliers and sums memory, all MAX_HARMONICS of them, then through a drain. A slice end
// then emits each harmonic in turn: two 64-step divides for each part, none for an empty slice.
// Reset: rst clears control state, the weight total, the slice counter and the config registers;
// the sums memory is not cleared, a fresh-slice flag makes it read as zero instead.
// Stalls: busy holds off new particles; results cannot be stalled by the receiver.
module harmonic_bunching_field_unit #(
  parameter int MAX_HARMONICS   = hbf_pkg::MAX_HARMONICS_DEF,
  parameter int MAX_SLICES      = hbf_pkg::MAX_SLICES_DEF,
  parameter int SINE_TABLE_BITS = hbf_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] phase,
  input  logic [15:0] weight,
  input  logic        slice_end,
  output logic        result_strobe,
  output logic [9:0]  slice_index,
  output logic [3:0]  harmonic,
  output logic signed [31:0] field_real,
  output logic signed [31:0] field_imag,
  output logic        empty_slice,
  output logic        last_of_run,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import hbf_pkg::*;

  localparam int HW     = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
  localparam int SW     = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
  localparam int B      = SINE_TABLE_BITS;
  localparam int QSIZE  = 1 << (B - 2);
  localparam int XR_W   = B - 1;          // holds 0..QSIZE
  localparam int ROM_W  = SINE_W * (QSIZE + 1);
  localparam int MEM_W  = 2 * ACC_W;

  // Build the quarter-wave sine table at elaboration
  function automatic logic [ROM_W-1:0] build_rom();
    longint x, x2, in1, in2, y, s;
    logic [ROM_W-1:0] v;
    v = '0;
    for (int i = 0; i <= QSIZE; i++) begin
      x   = longint'(i) << (18 - B);
      x2  = (x * x) >> 16;
      in1 = POLY_B - ((x2 * POLY_C) >> 16);
      in2 = POLY_A - ((x2 * in1) >> 16);
      y   = (x * in2) >> 16;
      s   = (y + 1) >> 1;
      if (s > 32767) s = 32767;
      if (s < 0) s = 0;
      v[i*SINE_W +: SINE_W] = SINE_W'(s);
    end
    return v;
  endfunction

  localparam logic [ROM_W-1:0] SINE_ROM = build_rom();

  // ---------------------------------------------------------------- registers
  logic [3:0]          harmonic_count;
  logic [31:0]         field_scale;
  state_t              state, state_next;
  logic [15:0]         phase_acc, weight_q;
  logic [15:0]         phase_base;
  logic                end_q;
  logic [HW-1:0]       k;
  logic [WT_W-1:0]     weight_total;
  logic [SW-1:0]       slice_counter;
  logic                fresh;

  // sums memory: sine sum in the upper half, cosine sum in the lower
  logic [MEM_W-1:0]    sums_mem [MAX_HARMONICS];
  logic [MEM_W-1:0]    mem_q;
  logic [HW-1:0]       rd_addr;

  // accumulate loop stages
  logic                v1, v2;
  logic [HW-1:0]       k1, k2;
  logic [SINE_W-1:0]   sin_q, cos_q;
  logic                sin_neg_q, cos_neg_q;
  logic [MEM_W-1:0]    old_q;
  logic signed [ACC_W-1:0] prod_s, prod_c;

  // emission datapath
  logic [HW-1:0]       e;
  logic                part;
  logic [ACC_W-1:0]    sum_s, sum_c;
  logic                sgn;
  logic [DIV_W-1:0]    num;
  logic [WT_W:0]       rem;
  logic [WT_W-1:0]     den;
  logic [DCNT_W-1:0]   dcnt;
  logic [30:0]         m_mag;
  logic [62:0]         prod;
  logic [31:0]         res_real, res_imag;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      harmonic_count <= HC_RESET;
      field_scale    <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HARMONIC_COUNT: harmonic_count <= cfg_data[3:0];
        CFG_FIELD_SCALE:    field_scale    <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective harmonic count: zero acts as one, clamp to the depth
  logic [CMP_W-1:0] eff_count;
  always_comb begin
    if (harmonic_count == 4'd0) eff_count = CMP_W'(1);
    else if (CMP_W'(harmonic_count) > CMP_W'(MAX_HARMONICS)) eff_count = CMP_W'(MAX_HARMONICS);
    else eff_count = CMP_W'(harmonic_count);
  end

  logic last_e;
  assign last_e = (CMP_W'(e) + CMP_W'(1)) == eff_count;

  // ---------------------------------------------------------------- stage 0: ROM address
  logic [B-1:0]    idx, cidx;
  logic [XR_W-1:0] xr_s, xr_c;
  assign idx  = phase_acc[15 -: B];
  assign cidx = idx + B'(QSIZE);
  always_comb begin
    xr_s = idx[B-2]  ? XR_W'(QSIZE) - XR_W'(idx[B-3:0])  : XR_W'(idx[B-3:0]);
    xr_c = cidx[B-2] ? XR_W'(QSIZE) - XR_W'(cidx[B-3:0]) : XR_W'(cidx[B-3:0]);
  end

  logic issue;
  assign issue = (state == ST_ACC);

  always_ff @(posedge clk) begin
    sin_q     <= SINE_ROM[xr_s*SINE_W +: SINE_W];
    cos_q     <= SINE_ROM[xr_c*SINE_W +: SINE_W];
    sin_neg_q <= idx[B-1];
    cos_neg_q <= cidx[B-1];
    k1        <= k;
  end

  // memory port: one registered read, one write
  assign rd_addr = issue ? k : e;

  always_ff @(posedge clk) begin
    mem_q <= sums_mem[rd_addr];
  end

  // ---------------------------------------------------------------- stage 1: multiply
  logic [30:0] mag_s, mag_c;
  assign mag_s = weight_q * sin_q;
  assign mag_c = weight_q * cos_q;

  always_ff @(posedge clk) begin
    prod_s <= sin_neg_q ? -$signed(ACC_W'(mag_s)) : $signed(ACC_W'(mag_s));
    prod_c <= cos_neg_q ? -$signed(ACC_W'(mag_c)) : $signed(ACC_W'(mag_c));
    old_q  <= mem_q;
    k2     <= k1;
  end

  // ---------------------------------------------------------------- stage 2: saturating add
  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] t;
    t = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (t[ACC_W] != t[ACC_W-1])
      return t[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    return t[ACC_W-1:0];
  endfunction

  logic [ACC_W-1:0] base_s, base_c;
  assign base_s = fresh ? '0 : old_q[MEM_W-1 -: ACC_W];
  assign base_c = fresh ? '0 : old_q[ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (v2) sums_mem[k2] <= {sat_add(base_s, prod_s), sat_add(base_c, prod_c)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  // ---------------------------------------------------------------- state machine
  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (start) state_next = ST_ACC;
      ST_ACC:     if (k == HW'(MAX_HARMONICS - 1)) state_next = ST_DRAIN;
      ST_DRAIN:   if (!v1 && !v2) state_next = end_q ? ST_EMIT_RD : ST_IDLE;
      ST_EMIT_RD: state_next = ST_EMIT_LD;
      ST_EMIT_LD: state_next = (weight_total == '0) ? ST_OUT : ST_LOAD1;
      ST_LOAD1:   state_next = ST_DIV1;
      ST_DIV1:    if (dcnt == '1) state_next = ST_CLAMP;
      ST_CLAMP:   state_next = ST_MUL_LO;
      ST_MUL_LO:  state_next = ST_MUL_HI;
      ST_MUL_HI:  state_next = ST_LOAD2;
      ST_LOAD2:   state_next = ST_DIV2;
      ST_DIV2:    if (dcnt == '1) state_next = ST_FIN;
      ST_FIN:     state_next = part ? ST_OUT : ST_LOAD1;
      ST_OUT:     state_next = last_e ? ST_IDLE : ST_EMIT_RD;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Control registers: particle capture, harmonic step, slice bookkeeping
  logic [WT_W:0] wt_sum;
  assign wt_sum = {1'b0, weight_total} + (WT_W+1)'(weight);

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_total  <= '0;
      slice_counter <= '0;
      fresh         <= 1'b1;
      k             <= '0;
      e             <= '0;
      part          <= 1'b0;
    end else begin
      if (accept) begin
        // saturate the weight total at its full range
        weight_total <= wt_sum[WT_W] ? '1 : wt_sum[WT_W-1:0];
        k            <= '0;
      end
      if (issue) k <= k + HW'(1);
      if (state == ST_DRAIN && !v1 && !v2) begin
        fresh <= 1'b0;
        e     <= '0;
      end
      if (state == ST_EMIT_LD) part <= 1'b0;
      if (state == ST_FIN) part <= 1'b1;
      if (state == ST_OUT) begin
        if (last_e) begin
          // drop the slice: sums read as zero until the next particle writes them
          fresh         <= 1'b1;
          weight_total  <= '0;
          slice_counter <= (slice_counter == SW'(MAX_SLICES - 1)) ? '0
                                                                  : slice_counter + SW'(1);
        end else begin
          e <= e + HW'(1);
        end
      end
    end
  end

  // Particle payload and harmonic phase walk (h * phase, modulo a turn)
  always_ff @(posedge clk) begin
    if (accept) begin
      phase_acc  <= phase;
      phase_base <= phase;
      weight_q   <= weight;
      end_q      <= slice_end;
    end else if (issue) begin
      phase_acc <= phase_acc + phase_base;
    end
  end

  // ---------------------------------------------------------------- emission datapath
  logic [ACC_W-1:0] sum_sel, sum_abs;
  assign sum_sel = part ? sum_c : sum_s;
  assign sum_abs = sum_sel[ACC_W-1] ? -sum_sel : sum_sel;

  logic        scale_neg;
  logic [31:0] scale_mag;
  assign scale_neg = field_scale[31];
  assign scale_mag = scale_neg ? -field_scale : field_scale;

  // one restoring step of the shared divider
  logic [WT_W:0] rem_sh, rem_sub;
  logic          q_bit;
  assign rem_sh  = {rem[WT_W-1:0], num[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign q_bit   = !rem_sub[WT_W];

  // final sign and saturation of the field
  logic        res_neg;
  logic [31:0] res_val;
  assign res_neg = sgn ^ scale_neg;
  always_comb begin
    if (res_neg)                 res_val = -num[31:0];
    else if (num[DIV_W-1:31] != '0) res_val = 32'h7FFF_FFFF;
    else                         res_val = num[31:0];
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_EMIT_LD: begin
        sum_s    <= mem_q[MEM_W-1 -: ACC_W];
        sum_c    <= mem_q[ACC_W-1:0];
        res_real <= '0;
        res_imag <= '0;
      end
      ST_LOAD1: begin
        sgn  <= sum_sel[ACC_W-1];
        num  <= DIV_W'(sum_abs) << 15;
        den  <= weight_total;
        rem  <= '0;
        dcnt <= '0;
      end
      ST_DIV1, ST_DIV2: begin
        rem  <= q_bit ? rem_sub : rem_sh;
        num  <= {num[DIV_W-2:0], q_bit};
        dcnt <= dcnt + DCNT_W'(1);
      end
      ST_CLAMP: begin
        // clamp the mean to one in Q30
        m_mag <= (num > DIV_W'(1 << 30)) ? 31'(1 << 30) : num[30:0];
      end
      ST_MUL_LO: prod <= 63'(scale_mag) * 63'(m_mag[15:0]);
      ST_MUL_HI: prod <= prod + ((63'(scale_mag) * 63'(m_mag[30:16])) << 16);
      ST_LOAD2: begin
        num  <= DIV_W'(prod[62:30]);
        den  <= WT_W'(e) + WT_W'(1);
        rem  <= '0;
        dcnt <= '0;
      end
      ST_FIN: begin
        if (part) res_imag <= res_val;
        else      res_real <= res_val;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- result port
  assign result_strobe = (state == ST_OUT);
  assign slice_index   = 10'(slice_counter);
  assign harmonic      = 4'(CMP_W'(e) + CMP_W'(1));
  assign field_real    = res_real;
  assign field_imag    = res_imag;
  assign empty_slice   = (weight_total == '0);
  assign last_of_run   = result_strobe && last_e;

  // ---------------------------------------------------------------- assertions
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy) else $error("result outside a transaction");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted particle did not raise busy");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last_of_run) |=> !result_strobe)
    else $error("result after last of run");

  a_no_write_emit: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (state == ST_ACC || state == ST_DRAIN))
    else $error("sums written during emission");

endmodule
